// ===== hdl/fse_pkg.sv =====
// Shared constants and types for the floor span extractor.
`default_nettype none

package fse_pkg;

  localparam int FSE_DEF_MAX_HALF_HEIGHT = 64;
  localparam int FSE_DEF_MAX_WIDTH       = 512;
  localparam int FSE_LEVEL_SHIFT         = 3;
  localparam int FSE_WALL_BITS           = 13;
  localparam int FSE_HEIGHT_BITS         = FSE_WALL_BITS - FSE_LEVEL_SHIFT;
  localparam int FSE_HALF_BITS           = 7;
  localparam int FSE_COL_BITS            = 9;
  localparam int FSE_ROW_BITS            = 6;
  localparam logic [FSE_HALF_BITS-1:0] FSE_HALF_RESET = 7'd64;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DOWN,
    S_RD,
    S_LOAD
  } fse_state_t;

endpackage

`default_nettype wire

// ===== hdl/floor_span_extractor.sv =====
// Floor span extractor: per-column wall heights in, horizontal floor spans out.
//
// Each input transaction is one screen column. Its row level (wall height >> 3)
// is compared with the current level: a drop records this column as the start
// of every row passed, one row per cycle into a small start-column memory; a
// rise (clamped to the effective half height) emits one span per row passed, in
// rising row order, and a last column then flushes all rows up to the half
// height. Each emitted span is a start-memory read (S_RD) followed by a load of
// the output register (S_LOAD), which waits while the output side stalls. The
// output register lets a finished span wait while the block moves on.
// half_height is clamped to 1..MAX_HALF_HEIGHT and should only be written while
// no column is in progress.
`default_nettype none

module floor_span_extractor
  import fse_pkg::*;
#(
  parameter int MAX_HALF_HEIGHT = FSE_DEF_MAX_HALF_HEIGHT,
  parameter int MAX_WIDTH       = FSE_DEF_MAX_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [FSE_HALF_BITS-1:0] cfg_wr_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [FSE_WALL_BITS-1:0] in_wall_height,
  input  wire logic                     in_last_column,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [FSE_COL_BITS-1:0]       out_span_start,
  output logic [FSE_COL_BITS-1:0]       out_span_end,
  output logic [FSE_ROW_BITS-1:0]       out_span_row,
  output logic                          out_last
);

  localparam int LW = $clog2(MAX_HALF_HEIGHT + 1);
  localparam int AW = (MAX_HALF_HEIGHT > 1) ? $clog2(MAX_HALF_HEIGHT) : 1;
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HW = FSE_HEIGHT_BITS;
  localparam logic [LW-1:0] LVL_MAX = LW'(MAX_HALF_HEIGHT);
  localparam logic [CW-1:0] COL_LAST = CW'(MAX_WIDTH - 1);

  fse_state_t state_r, state_nxt;

  logic [FSE_HALF_BITS-1:0] cfg_half_r;
  logic [LW-1:0]            lvl_r, lvl_nxt;
  logic [LW-1:0]            tgt_r, tgt_nxt;
  logic [LW-1:0]            half_r, half_nxt;
  logic [CW-1:0]            col_r, col_nxt;
  logic [CW-1:0]            x_r, x_nxt;
  logic [CW-1:0]            end_r, end_nxt;
  logic                     in_frame_r, in_frame_nxt;
  logic                     last_col_r, last_col_nxt;
  logic                     flush_r, flush_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [FSE_COL_BITS-1:0]  out_start_r, out_end_r;
  logic [FSE_ROW_BITS-1:0]  out_row_r;
  logic                     out_last_r;
  logic                     out_load;

  logic [FSE_COL_BITS-1:0]  mem [MAX_HALF_HEIGHT];
  logic [FSE_COL_BITS-1:0]  rd_data_r;
  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_addr;

  logic [LW-1:0]            eff_half;
  logic [LW-1:0]            lvl0;
  logic [CW-1:0]            x0;
  logic [CW-1:0]            prev0;
  logic [HW-1:0]            height;
  logic [HW-1:0]            lvl0_ext;
  logic [LW-1:0]            up_tgt;
  logic [LW-1:0]            lvl_dec;
  logic [LW-1:0]            lvl_inc;
  logic                     in_acc;

  always_comb begin
    if (cfg_half_r == '0) begin
      eff_half = LW'(1);
    end else if (LW'(cfg_half_r) > LVL_MAX || (FSE_HALF_BITS > LW &&
                 (cfg_half_r >> LW) != '0)) begin
      eff_half = LVL_MAX;
    end else begin
      eff_half = LW'(cfg_half_r);
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign height   = HW'(in_wall_height >> FSE_LEVEL_SHIFT);
  assign lvl0     = in_frame_r ? lvl_r : eff_half;
  assign x0       = in_frame_r ? col_r : '0;
  assign prev0    = (x0 == '0) ? COL_LAST : x0 - CW'(1);
  assign lvl0_ext = HW'(lvl0);
  assign up_tgt   = (height > HW'(eff_half)) ? eff_half : LW'(height);
  assign lvl_dec  = lvl_r - LW'(1);
  assign lvl_inc  = lvl_r + LW'(1);
  assign out_load = (state_r == S_LOAD) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_half_r  <= FSE_HALF_RESET;
      in_frame_r  <= 1'b0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_frame_r  <= in_frame_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_half_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    tgt_r      <= tgt_nxt;
    half_r     <= half_nxt;
    x_r        <= x_nxt;
    end_r      <= end_nxt;
    last_col_r <= last_col_nxt;
    flush_r    <= flush_nxt;
    if (out_load) begin
      out_start_r <= rd_data_r;
      out_end_r   <= FSE_COL_BITS'(end_r);
      out_row_r   <= FSE_ROW_BITS'(lvl_r);
      out_last_r  <= (lvl_inc == tgt_r) && !flush_r;
    end
  end

  // Start-column store: one write or one read per cycle, registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= FSE_COL_BITS'(x_r);
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    tgt_nxt       = tgt_r;
    half_nxt      = half_r;
    x_nxt         = x_r;
    end_nxt       = end_r;
    last_col_nxt  = last_col_r;
    flush_nxt     = flush_r;
    in_frame_nxt  = in_frame_r;
    col_nxt       = col_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = AW'(lvl_r);
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          lvl_nxt      = lvl0;
          half_nxt     = eff_half;
          x_nxt        = x0;
          last_col_nxt = in_last_column;
          in_frame_nxt = !in_last_column;
          col_nxt      = (x0 == COL_LAST) ? '0 : x0 + CW'(1);
          if (height < lvl0_ext) begin
            tgt_nxt   = LW'(height);
            state_nxt = S_DOWN;
          end else if (height > lvl0_ext && up_tgt > lvl0) begin
            tgt_nxt   = up_tgt;
            end_nxt   = prev0;
            flush_nxt = in_last_column && (up_tgt < eff_half);
            state_nxt = S_RD;
          end else if (in_last_column && lvl0 < eff_half) begin
            tgt_nxt   = eff_half;
            end_nxt   = x0;
            flush_nxt = 1'b0;
            state_nxt = S_RD;
          end
        end
      end
      S_DOWN: begin
        mem_we   = 1'b1;
        mem_addr = AW'(lvl_dec);
        lvl_nxt  = lvl_dec;
        if (lvl_dec == tgt_r) begin
          if (last_col_r && lvl_dec < half_r) begin
            tgt_nxt   = half_r;
            end_nxt   = x_r;
            flush_nxt = 1'b0;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          lvl_nxt       = lvl_inc;
          if (lvl_inc != tgt_r) begin
            state_nxt = S_RD;
          end else if (flush_r) begin
            // The rise is done; the last column now flushes the remaining rows.
            tgt_nxt   = half_r;
            end_nxt   = x_r;
            flush_nxt = 1'b0;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_span_start = out_start_r;
  assign out_span_end   = out_end_r;
  assign out_span_row   = out_row_r;
  assign out_last       = out_last_r;

  a_down_above_target: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DOWN) |-> (lvl_r > tgt_r))
    else $error("record pass entered with level not above target");

  a_emit_below_target: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_LOAD) |-> (lvl_r < tgt_r && tgt_r <= half_r))
    else $error("span emission outside the valid row range");

  a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |=> (state_r == S_LOAD))
    else $error("memory read not followed by output load");

  a_frame_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_column) |=> !in_frame_r)
    else $error("frame still open after last column");

endmodule

`default_nettype wire

// ===== dv/fse_span_checker.sv =====
`timescale 1ns / 1ps
// Span checker: watches both channels, predicts the spans of each column and compares them.
module fse_span_checker
  import fse_pkg::*;
#(
  parameter int MAX_HALF_HEIGHT = FSE_DEF_MAX_HALF_HEIGHT,
  parameter int MAX_WIDTH       = FSE_DEF_MAX_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [FSE_HALF_BITS-1:0] cfg_wr_data,
  input  wire logic                     in_valid,
  input  wire logic                     in_ready,
  input  wire logic [FSE_WALL_BITS-1:0] in_wall_height,
  input  wire logic                     in_last_column,
  input  wire logic                     out_valid,
  input  wire logic                     out_ready,
  input  wire logic [FSE_COL_BITS-1:0]  out_span_start,
  input  wire logic [FSE_COL_BITS-1:0]  out_span_end,
  input  wire logic [FSE_ROW_BITS-1:0]  out_span_row,
  input  wire logic                     out_last,
  output int                            failures,
  output int                            spans_pending,
  output int                            spans_checked,
  output int                            columns_taken
);

  typedef struct packed {
    logic [FSE_COL_BITS-1:0] start_col;
    logic [FSE_COL_BITS-1:0] end_col;
    logic [FSE_ROW_BITS-1:0] row;
    logic                    last;
  } span_t;

  span_t                   expected_spans[$];
  logic [FSE_HALF_BITS-1:0] half_reg;
  logic [FSE_COL_BITS-1:0] row_start[MAX_HALF_HEIGHT];
  int                      level;
  int                      column;
  bit                      frame_open;

  function automatic int usable_half();
    if (half_reg == '0) return 1;
    if (int'(half_reg) > MAX_HALF_HEIGHT) return MAX_HALF_HEIGHT;
    return int'(half_reg);
  endfunction

  function automatic void push_span(input int row, input int end_col);
    span_t s;
    s.start_col = (row < MAX_HALF_HEIGHT) ? row_start[row] : '0;
    s.end_col   = FSE_COL_BITS'(end_col);
    s.row       = FSE_ROW_BITS'(row);
    s.last      = 1'b0;
    expected_spans.push_back(s);
  endfunction

  // Works out the spans that one accepted column produces and updates the model state.
  function automatic void project_column(input logic [FSE_WALL_BITS-1:0] wall,
                                         input logic last_col);
    int    half;
    int    target;
    int    x;
    int    prev;
    int    first;
    span_t tail;
    half   = usable_half();
    target = int'(wall >> FSE_LEVEL_SHIFT);
    if (!frame_open) begin
      level      = half;
      column     = 0;
      frame_open = 1'b1;
    end
    x     = column % MAX_WIDTH;
    prev  = (x == 0) ? MAX_WIDTH - 1 : x - 1;
    first = expected_spans.size();
    if (target < level) begin
      while (level > target) begin
        level--;
        if (level < MAX_HALF_HEIGHT) row_start[level] = FSE_COL_BITS'(x);
      end
    end else if (target > level) begin
      if (target > half) target = half;
      while (level < target) begin
        push_span(level, prev);
        level++;
      end
    end
    if (last_col) begin
      // The frame ends: every row still open closes at this column.
      while (level < half) begin
        push_span(level, x);
        level++;
      end
      frame_open = 1'b0;
    end
    column = (x + 1) % MAX_WIDTH;
    if (expected_spans.size() > first) begin
      tail      = expected_spans.pop_back();
      tail.last = 1'b1;
      expected_spans.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    span_t seen;
    span_t want;
    if (!rst_n) begin
      half_reg   = FSE_HALF_RESET;
      level      = int'(FSE_HALF_RESET);
      column     = 0;
      frame_open = 1'b0;
      expected_spans.delete();
      failures      = 0;
      spans_checked = 0;
      columns_taken = 0;
    end else begin
      if (in_valid && in_ready) begin
        project_column(in_wall_height, in_last_column);
        columns_taken++;
      end
      if (out_valid && out_ready) begin
        seen.start_col = out_span_start;
        seen.end_col   = out_span_end;
        seen.row       = out_span_row;
        seen.last      = out_last;
        if (expected_spans.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: span start=%0d end=%0d row=%0d last=%0b with no column behind it",
                     $realtime, seen.start_col, seen.end_col, seen.row, seen.last);
        end else begin
          want = expected_spans.pop_front();
          if (seen !== want) begin
            failures++;
            if (failures <= 10)
              $display({"%0t: span mismatch: expected start=%0d end=%0d row=%0d last=%0b,",
                        " got start=%0d end=%0d row=%0d last=%0b"},
                       $realtime, want.start_col, want.end_col, want.row, want.last,
                       seen.start_col, seen.end_col, seen.row, seen.last);
          end
        end
        spans_checked++;
      end
      if (cfg_wr_en) half_reg = cfg_wr_data;
    end
    spans_pending = expected_spans.size();
  end

endmodule

// ===== dv/tb_floor_span_extractor.sv =====
`timescale 1ns / 1ps
// Testbench top for the floor span extractor: clock, reset, column stimulus and verdict.
module tb_floor_span_extractor;
  import fse_pkg::*;

  localparam int RUN_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 300;

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     cfg_wr_en      = 1'b0;
  logic [FSE_HALF_BITS-1:0] cfg_wr_data    = '0;
  logic                     in_valid       = 1'b0;
  logic [FSE_WALL_BITS-1:0] in_wall_height = '0;
  logic                     in_last_column = 1'b0;
  logic                     out_ready      = 1'b0;
  logic                     in_ready;
  logic                     out_valid;
  logic [FSE_COL_BITS-1:0]  out_span_start;
  logic [FSE_COL_BITS-1:0]  out_span_end;
  logic [FSE_ROW_BITS-1:0]  out_span_row;
  logic                     out_last;

  int failures;
  int spans_pending;
  int spans_checked;
  int columns_taken;
  int cycle_count   = 0;
  int send_idle_pct = 32;
  int recv_idle_pct = 75;
  int half_in_use   = 64;
  bit hold_req      = 1'b0;
  bit hold_done     = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  floor_span_extractor dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_wall_height (in_wall_height),
    .in_last_column (in_last_column),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_span_start (out_span_start),
    .out_span_end   (out_span_end),
    .out_span_row   (out_span_row),
    .out_last       (out_last)
  );

  fse_span_checker span_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_wall_height (in_wall_height),
    .in_last_column (in_last_column),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_span_start (out_span_start),
    .out_span_end   (out_span_end),
    .out_span_row   (out_span_row),
    .out_last       (out_last),
    .failures       (failures),
    .spans_pending  (spans_pending),
    .spans_checked  (spans_checked),
    .columns_taken  (columns_taken)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d spans still due.",
               cycle_count, spans_pending);
      $display("floor_span_extractor regression: fail");
      $finish;
    end
  end

  // Span receiver. Once, it holds off for a long stretch so the block backs up into its input.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_column(input logic [FSE_WALL_BITS-1:0] wall, input logic last_col);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_wall_height <= wall;
    in_last_column <= last_col;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (spans_pending != 0) @(negedge clk);
    // A column that only records starts can still be busy after the last span.
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_half(input logic [FSE_HALF_BITS-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    if (value == '0) half_in_use = 1;
    else if (int'(value) > FSE_DEF_MAX_HALF_HEIGHT) half_in_use = FSE_DEF_MAX_HALF_HEIGHT;
    else half_in_use = int'(value);
  endtask

  function automatic logic [FSE_WALL_BITS-1:0] wall_for(input int lvl);
    return FSE_WALL_BITS'((lvl << FSE_LEVEL_SHIFT) | $urandom_range(0, 7));
  endfunction

  // Random frames of random length until at least item_goal columns have gone in.
  task automatic run_frames(input int item_goal);
    int                       sent;
    int                       frame_len;
    int                       lvl;
    int                       pick;
    logic [FSE_WALL_BITS-1:0] wall;
    sent = 0;
    while (sent < item_goal) begin
      if ($urandom_range(0, 99) < 30) begin
        case ($urandom_range(0, 5))
          0: write_half(7'd1);
          1: write_half(7'd64);
          2: write_half(7'd0);
          3: write_half(7'd127);
          4: write_half(FSE_HALF_BITS'($urandom_range(1, 127)));
          default: write_half(FSE_HALF_BITS'($urandom_range(1, 64)));
        endcase
      end
      frame_len = $urandom_range(1, 16);
      lvl       = $urandom_range(0, half_in_use);
      for (int i = 0; i < frame_len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          wall = FSE_WALL_BITS'($urandom);
        end else if (pick < 25) begin
          wall = wall_for(lvl);
        end else begin
          lvl  = $urandom_range(0, half_in_use + 2);
          wall = wall_for(lvl);
        end
        send_column(wall, i == frame_len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames. The first column drops to level 0 so every start entry gets written.
    send_column(13'd0, 1'b0);
    hold_req <= 1'b1;
    send_column(13'd8191, 1'b0);
    send_column(13'd24, 1'b0);
    send_column(13'd31, 1'b0);
    send_column(13'd87, 1'b0);
    send_column(13'd8, 1'b1);

    write_half(7'd1);
    send_column(13'd0, 1'b0);
    send_column(13'd4095, 1'b0);
    send_column(13'd7, 1'b1);

    // Zero acts as one; a frame can end on its first column with nothing to emit.
    write_half(7'd0);
    send_column(13'd16, 1'b1);
    send_column(13'd0, 1'b1);

    // Out-of-range values act as the maximum, and the value may change inside a frame.
    write_half(7'd127);
    send_column(13'd504, 1'b0);
    send_column(13'd0, 1'b0);
    write_half(7'd20);
    send_column(13'd8191, 1'b0);
    send_column(13'd200, 1'b0);
    write_half(7'd65);
    send_column(13'd400, 1'b0);
    send_column(13'd0, 1'b1);

    run_frames(32);

    send_idle_pct = 75;
    recv_idle_pct = 32;
    run_frames(32);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_half(7'd64);
    run_frames(32);

    wait_drained();
    $display("Checked %0d spans from %0d columns, half heights 0 to 127, with stalls both ways.",
             spans_checked, columns_taken);
    if (failures == 0) begin
      $display("floor_span_extractor regression: pass");
    end else begin
      $display("%0d span failures.", failures);
      $display("floor_span_extractor regression: fail");
    end
    $finish;
  end

endmodule
